### hw/rtl/cialu_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cialu_pkg: shared types and constants of the complex integer ALU
// Operation codes, widths and the word that travels down the divider chain.
// ============================================================================
package cialu_pkg;

    localparam int DW = 32;          // width of one operand or result part
    localparam int PW = 2 * DW;      // width of a product and of the divisor

    typedef enum logic [2:0] {
        ACT_ADD = 3'd0,
        ACT_SUB = 3'd1,
        ACT_MUL = 3'd2,
        ACT_DIV = 3'd3,
        ACT_NEG = 3'd4
    } action_t;

    // One word in flight through the divider chain.
    typedef struct packed {
        logic                 valid;
        logic                 div_op;
        logic                 zero_den;
        logic                 neg_re;
        logic                 neg_im;
        logic [PW-1:0]        den;
        logic [PW-1:0]        rem_re;
        logic [PW-1:0]        rem_im;
        logic [PW-1:0]        num_re;
        logic [PW-1:0]        num_im;
        logic [DW-1:0]        q_re;
        logic [DW-1:0]        q_im;
        logic signed [DW-1:0] res_re;
        logic signed [DW-1:0] res_im;
    } cell_word_t;

endpackage

### hw/rtl/cialu_front.sv
`timescale 1ns / 1ps
// ============================================================================
// cialu_front: product and numerator stages
// Two registered stages: the six products, then the sums, magnitudes and
// the results of the operations that need no division.
// ============================================================================
module cialu_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic [2:0]                   action,
    input  logic signed [cialu_pkg::DW-1:0] a_re,
    input  logic signed [cialu_pkg::DW-1:0] a_im,
    input  logic signed [cialu_pkg::DW-1:0] b_re,
    input  logic signed [cialu_pkg::DW-1:0] b_im,
    output cialu_pkg::cell_word_t        word
);

    localparam int DW = cialu_pkg::DW;
    localparam int PW = cialu_pkg::PW;

    // Stage one registers.
    logic                 v1_reg;
    logic [2:0]           act1_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg, sq_r_reg, sq_i_reg;
    logic signed [DW-1:0] lin_re_reg, lin_im_reg;
    logic signed [DW-1:0] lin_re_next, lin_im_next;

    // Stage two.
    cialu_pkg::cell_word_t word_reg, word_next;
    logic signed [PW:0]    n_re, n_im;
    logic [PW-1:0]         den;

    always_comb
    begin
        lin_re_next = '0;
        lin_im_next = '0;
        case (action)
            cialu_pkg::ACT_ADD:
            begin
                lin_re_next = a_re + b_re;
                lin_im_next = a_im + b_im;
            end
            cialu_pkg::ACT_SUB:
            begin
                lin_re_next = a_re - b_re;
                lin_im_next = a_im - b_im;
            end
            cialu_pkg::ACT_NEG:
            begin
                lin_re_next = -a_re;
                lin_im_next = -a_im;
            end
            default:
            begin
                lin_re_next = '0;
                lin_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        act1_reg   <= action;
        p_rr_reg   <= PW'(a_re * b_re);
        p_ii_reg   <= PW'(a_im * b_im);
        p_ri_reg   <= PW'(a_re * b_im);
        p_ir_reg   <= PW'(a_im * b_re);
        sq_r_reg   <= PW'(b_re * b_re);
        sq_i_reg   <= PW'(b_im * b_im);
        lin_re_reg <= lin_re_next;
        lin_im_reg <= lin_im_next;
    end

    always_comb
    begin
        n_re = {p_rr_reg[PW-1], p_rr_reg} + {p_ii_reg[PW-1], p_ii_reg};
        n_im = {p_ir_reg[PW-1], p_ir_reg} - {p_ri_reg[PW-1], p_ri_reg};
        den  = sq_r_reg + sq_i_reg;

        word_next          = '0;
        word_next.valid    = v1_reg;
        word_next.div_op   = (act1_reg == cialu_pkg::ACT_DIV);
        word_next.zero_den = (den == '0);
        word_next.neg_re   = n_re[PW];
        word_next.neg_im   = n_im[PW];
        word_next.den      = den;
        // The magnitude of a numerator never exceeds 2^(PW-1), so PW bits hold it.
        word_next.num_re   = n_re[PW] ? PW'(-n_re) : PW'(n_re);
        word_next.num_im   = n_im[PW] ? PW'(-n_im) : PW'(n_im);
        if (act1_reg == cialu_pkg::ACT_MUL)
        begin
            word_next.res_re = DW'(p_rr_reg - p_ii_reg);
            word_next.res_im = DW'(p_ri_reg + p_ir_reg);
        end
        else
        begin
            word_next.res_re = lin_re_reg;
            word_next.res_im = lin_im_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

### hw/rtl/cialu_div_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// cialu_div_cell: one restoring division step
// Takes one numerator bit into each partial remainder, subtracts the
// divisor where it fits and shifts the quotient bit in.
// ============================================================================
module cialu_div_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cialu_pkg::cell_word_t word_in,
    output cialu_pkg::cell_word_t word_out
);

    localparam int PW = cialu_pkg::PW;
    localparam int DW = cialu_pkg::DW;

    cialu_pkg::cell_word_t word_reg, word_next;
    logic [PW-1:0]         trial_re, trial_im;
    logic                  fit_re, fit_im;

    always_comb
    begin
        // The remainder stays below the divisor, so its top bit is always clear.
        trial_re = {word_in.rem_re[PW-2:0], word_in.num_re[PW-1]};
        trial_im = {word_in.rem_im[PW-2:0], word_in.num_im[PW-1]};
        fit_re   = (trial_re >= word_in.den);
        fit_im   = (trial_im >= word_in.den);

        word_next        = word_in;
        word_next.rem_re = fit_re ? trial_re - word_in.den : trial_re;
        word_next.rem_im = fit_im ? trial_im - word_in.den : trial_im;
        word_next.num_re = {word_in.num_re[PW-2:0], 1'b0};
        word_next.num_im = {word_in.num_im[PW-2:0], 1'b0};
        word_next.q_re   = {word_in.q_re[DW-2:0], fit_re};
        word_next.q_im   = {word_in.q_im[DW-2:0], fit_im};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word_out = word_reg;

endmodule

### hw/rtl/complex_integer_alu_core.sv
`timescale 1ns / 1ps
// ============================================================================
// complex_integer_alu_core: pipelined complex integer arithmetic unit
// Adds, subtracts, multiplies, divides or negates signed complex words.
// ============================================================================
// Usage:
//   A word is taken at each rising edge where start is high and busy is
//   low. busy is always low: the unit is fully pipelined and takes a new
//   word in every cycle, so the sustained rate is one word per clock.
//   Each word produces exactly one result, shown on r_re, r_im and
//   div_by_zero for a single cycle with done high. The receiver cannot
//   stall the unit and must take the result in that cycle.
//   Every operation passes the same registers: the front stages for the
//   products and numerator sums, the chain of division cells (one
//   quotient bit per cell, their number set by the 64-bit width of the
//   divisor's squared magnitude), and one output register. Results leave
//   in the order the words entered.
//   The divide takes the conjugate product and divides both numerators by
//   |b|^2 with truncation toward zero; a zero divisor gives zero parts
//   and raises div_by_zero. All parts wrap to 32 bits.
//   Reset clears every valid flag in the pipeline, so no result appears
//   until a word has been taken after reset.
// ============================================================================
module complex_integer_alu_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          action,
    input  logic signed [31:0]  a_re,
    input  logic signed [31:0]  a_im,
    input  logic signed [31:0]  b_re,
    input  logic signed [31:0]  b_im,
    output logic                done,
    output logic signed [31:0]  r_re,
    output logic signed [31:0]  r_im,
    output logic                div_by_zero
);

    localparam int PW = cialu_pkg::PW;
    localparam int DW = cialu_pkg::DW;

    // The chain holds the front word plus one word per division cell.
    cialu_pkg::cell_word_t chain [PW+1];
    cialu_pkg::cell_word_t last;

    logic                 done_reg;
    logic signed [DW-1:0] r_re_reg, r_im_reg, r_re_next, r_im_next;
    logic                 dbz_reg, dbz_next;

    assign busy = 1'b0;

    cialu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .action   (action),
        .a_re     (a_re),
        .a_im     (a_im),
        .b_re     (b_re),
        .b_im     (b_im),
        .word     (chain[0])
    );

    for (genvar k = 0; k < PW; k++)
    begin : g_cell
        cialu_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .word_in  (chain[k]),
            .word_out (chain[k+1])
        );
    end

    assign last = chain[PW];

    // Select the final parts: the quotient with its sign restored, or the
    // result carried along the chain for the other operations.
    always_comb
    begin
        r_re_next = last.res_re;
        r_im_next = last.res_im;
        dbz_next  = 1'b0;
        if (last.div_op)
        begin
            if (last.zero_den)
            begin
                r_re_next = '0;
                r_im_next = '0;
                dbz_next  = 1'b1;
            end
            else
            begin
                r_re_next = last.neg_re ? -last.q_re : last.q_re;
                r_im_next = last.neg_im ? -last.q_im : last.q_im;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        r_re_reg <= r_re_next;
        r_im_reg <= r_im_next;
        dbz_reg  <= dbz_next;
    end

    assign done        = done_reg;
    assign r_re        = r_re_reg;
    assign r_im        = r_im_reg;
    assign div_by_zero = dbz_reg;

endmodule
